[rtl/vfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_pkg
// Shared types and status reduction functions for the fault supervisor.
// ----------------------------------------------------------------------------
package vfs_pkg;

	localparam int BatteryWidth   = 12;
	localparam int ConverterWidth = 4;
	localparam int InverterWidth  = 12;

	typedef enum logic [1:0] {
		H_OK           = 2'd0,
		H_REGULAR      = 2'd1,
		H_PROBLEM      = 2'd2,
		H_DATA_PROBLEM = 2'd3
	} health_t;

	typedef enum logic [1:0] {
		LVL_OK       = 2'd0,
		LVL_CAUTION1 = 2'd1,
		LVL_CAUTION2 = 2'd2,
		LVL_AUTOKILL = 2'd3
	} level_t;

	typedef struct packed {
		health_t battery;
		health_t converter;
		health_t inverter;
	} status_t;

	// r0..r2: codes that alone raise REGULAR; v, c, p: voltage, current, power
	function automatic health_t six_code_status(
		input health_t r0, input health_t r1, input health_t r2,
		input health_t v, input health_t c, input health_t p
	);
		health_t res;
		if (r0 == H_OK && r1 == H_OK && r2 == H_OK &&
			v == H_OK && c == H_OK && p == H_OK) begin
			res = H_OK;
		end else if (r0 == H_REGULAR || r1 == H_REGULAR || r2 == H_REGULAR ||
			(v == H_REGULAR && c == H_REGULAR && p == H_REGULAR)) begin
			res = H_REGULAR;
		end else if (r0 == H_PROBLEM || r1 == H_PROBLEM || r2 == H_PROBLEM ||
			v == H_PROBLEM || c == H_PROBLEM || p == H_PROBLEM) begin
			res = H_PROBLEM;
		end else begin
			res = H_DATA_PROBLEM;
		end
		return res;
	endfunction

	function automatic health_t pair_status(input health_t t, input health_t v);
		health_t res;
		if (t == H_OK && v == H_OK) begin
			res = H_OK;
		end else if (t == H_REGULAR || v == H_REGULAR) begin
			res = H_REGULAR;
		end else if (t == H_PROBLEM || v == H_PROBLEM) begin
			res = H_PROBLEM;
		end else begin
			res = H_DATA_PROBLEM;
		end
		return res;
	endfunction

endpackage

[rtl/vfs_status.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_status
// Reduces the per-module health codes to one status per module.
// ----------------------------------------------------------------------------
module vfs_status (
	input  logic [vfs_pkg::BatteryWidth-1:0]   battery_codes,
	input  logic [vfs_pkg::ConverterWidth-1:0] converter_codes,
	input  logic [vfs_pkg::InverterWidth-1:0]  inverter_codes,
	output vfs_pkg::status_t                   status
);

	always_comb begin
		status.battery = vfs_pkg::six_code_status(
			vfs_pkg::health_t'(battery_codes[11:10]),
			vfs_pkg::health_t'(battery_codes[9:8]),
			vfs_pkg::health_t'(battery_codes[5:4]),
			vfs_pkg::health_t'(battery_codes[1:0]),
			vfs_pkg::health_t'(battery_codes[3:2]),
			vfs_pkg::health_t'(battery_codes[7:6]));
		status.converter = vfs_pkg::pair_status(
			vfs_pkg::health_t'(converter_codes[1:0]),
			vfs_pkg::health_t'(converter_codes[3:2]));
		status.inverter = vfs_pkg::six_code_status(
			vfs_pkg::health_t'(inverter_codes[1:0]),
			vfs_pkg::health_t'(inverter_codes[7:6]),
			vfs_pkg::health_t'(inverter_codes[9:8]),
			vfs_pkg::health_t'(inverter_codes[3:2]),
			vfs_pkg::health_t'(inverter_codes[5:4]),
			vfs_pkg::health_t'(inverter_codes[11:10]));
	end

endmodule

[rtl/vfs_fsm.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vfs_fsm
// Four-level fault machine; advances once per request on the module statuses.
// ----------------------------------------------------------------------------
module vfs_fsm (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  vfs_pkg::status_t  status,
	output vfs_pkg::level_t   level
);

	vfs_pkg::level_t state_q;
	vfs_pkg::level_t state_next;
	logic kill;
	logic any_problem;
	logic any_regular;
	logic all_ok;
	logic all_mild;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vfs_pkg::LVL_CAUTION1;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	always_comb begin
		kill = status.battery == vfs_pkg::H_PROBLEM &&
			status.converter == vfs_pkg::H_PROBLEM &&
			status.inverter == vfs_pkg::H_PROBLEM;
		any_problem = status.battery == vfs_pkg::H_PROBLEM ||
			status.converter == vfs_pkg::H_PROBLEM ||
			status.inverter == vfs_pkg::H_PROBLEM;
		any_regular = status.battery == vfs_pkg::H_REGULAR ||
			status.converter == vfs_pkg::H_REGULAR ||
			status.inverter == vfs_pkg::H_REGULAR;
		all_ok = status.battery == vfs_pkg::H_OK &&
			status.converter == vfs_pkg::H_OK &&
			status.inverter == vfs_pkg::H_OK;
		all_mild = (status.battery == vfs_pkg::H_OK ||
			status.battery == vfs_pkg::H_REGULAR) &&
			(status.converter == vfs_pkg::H_OK ||
			status.converter == vfs_pkg::H_REGULAR) &&
			(status.inverter == vfs_pkg::H_OK ||
			status.inverter == vfs_pkg::H_REGULAR);

		state_next = state_q;
		level = state_q;
		if (state_q != vfs_pkg::LVL_AUTOKILL && kill) begin
			state_next = vfs_pkg::LVL_AUTOKILL;
		end else begin
			case (state_q)
				vfs_pkg::LVL_OK: begin
					if (any_problem) begin
						state_next = vfs_pkg::LVL_CAUTION2;
					end else if (any_regular) begin
						state_next = vfs_pkg::LVL_CAUTION1;
					end
				end
				vfs_pkg::LVL_CAUTION1: begin
					if (any_problem) begin
						state_next = vfs_pkg::LVL_CAUTION2;
					end else if (all_ok) begin
						state_next = vfs_pkg::LVL_OK;
					end
				end
				vfs_pkg::LVL_CAUTION2: begin
					if (all_mild) begin
						state_next = vfs_pkg::LVL_CAUTION1;
					end
				end
				default: begin
					state_next = state_q;
				end
			endcase
		end
	end

endmodule

[rtl/vehicle_fault_supervisor_top.sv]
`timescale 1ns / 1ps
// A request is held in the input register, then in the result register, which drives out_valid.
// Throughput: one request per cycle while unstalled; the fault level register is the only loop.
// Result register frees in the cycle it is taken; the input waits only while a result is held.
// Reset (arst_n low, asynchronous): fault level CAUTION1, both stages empty.
// ----------------------------------------------------------------------------
// vehicle_fault_supervisor_top
// Per-tick module status reduction and fault level supervision.
// ----------------------------------------------------------------------------
module vehicle_fault_supervisor_top (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [vfs_pkg::BatteryWidth-1:0]   battery_codes,
	input  logic [vfs_pkg::ConverterWidth-1:0] converter_codes,
	input  logic [vfs_pkg::InverterWidth-1:0]  inverter_codes,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [1:0]                         fault_level,
	output logic                               kill_flag,
	output logic [1:0]                         battery_status,
	output logic [1:0]                         converter_status,
	output logic [1:0]                         inverter_status
);

	logic                               valid_s1;
	logic [vfs_pkg::BatteryWidth-1:0]   battery_s1;
	logic [vfs_pkg::ConverterWidth-1:0] converter_s1;
	logic [vfs_pkg::InverterWidth-1:0]  inverter_s1;
	logic                               valid_s2;
	vfs_pkg::level_t                    level_s2;
	vfs_pkg::status_t                   status_s2;
	vfs_pkg::status_t                   status;
	vfs_pkg::level_t                    level;
	logic                               s2_load;

	assign s2_load  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !s2_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			battery_s1   <= battery_codes;
			converter_s1 <= converter_codes;
			inverter_s1  <= inverter_codes;
		end
	end

	vfs_status u_status (
		.battery_codes   (battery_s1),
		.converter_codes (converter_s1),
		.inverter_codes  (inverter_s1),
		.status          (status)
	);

	vfs_fsm u_fsm (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (s2_load),
		.status  (status),
		.level   (level)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_load) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			level_s2  <= level;
			status_s2 <= status;
		end
	end

	assign out_valid        = valid_s2;
	assign fault_level      = level_s2;
	assign kill_flag        = level_s2 == vfs_pkg::LVL_AUTOKILL;
	assign battery_status   = status_s2.battery;
	assign converter_status = status_s2.converter;
	assign inverter_status  = status_s2.inverter;

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the vehicle fault supervisor. A directed run walks
// the OK, CAUTION1 and CAUTION2 transitions other than CAUTION1 to CAUTION2,
// and the status reduction corner cases. A long random run follows, with
// traffic aimed at chosen module statuses, and it ends in autokill. Bursty
// requests meet a randomly stalling receiver, and one long hold-off fills
// the block. Every result is checked against a local prediction.
// ----------------------------------------------------------------------------
module tb;
	import vfs_pkg::*;

	localparam int          RandomTicks      = 650;
	localparam int          KillTick         = 615;
	localparam int          CycleLimit       = 100000;
	localparam int          HoldoffAfter     = 300;
	localparam int          HoldoffCycles    = 150;
	localparam logic [5:0]  BatteryLoneMask  = 6'b110100;
	localparam logic [5:0]  InverterLoneMask = 6'b011001;

	typedef struct {
		logic [BatteryWidth-1:0]   battery;
		logic [ConverterWidth-1:0] converter;
		logic [InverterWidth-1:0]  inverter;
	} tick_codes_t;

	typedef struct {
		level_t  level;
		logic    kill;
		health_t battery;
		health_t converter;
		health_t inverter;
	} tick_verdict_t;

	typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_BEAT} rx_mode_t;

	logic                      clk              = 1'b0;
	logic                      arst_n           = 1'b0;
	logic                      in_valid         = 1'b0;
	logic                      in_stall;
	logic [BatteryWidth-1:0]   battery_codes    = '0;
	logic [ConverterWidth-1:0] converter_codes  = '0;
	logic [InverterWidth-1:0]  inverter_codes   = '0;
	logic                      out_valid;
	logic                      out_stall        = 1'b0;
	logic [1:0]                fault_level;
	logic                      kill_flag;
	logic [1:0]                battery_status;
	logic [1:0]                converter_status;
	logic [1:0]                inverter_status;

	tick_codes_t   tick_q[$];
	tick_verdict_t verdict_q[$];
	tick_codes_t   tick_cur;
	tick_verdict_t verdict_cur;
	level_t        level_model;
	logic          req_taken     = 1'b0;
	int            accepted_cnt  = 0;
	int            error_cnt     = 0;
	int            cycle_cnt     = 0;
	int            gap_left      = 0;
	int            burst_left    = 1;
	int            holdoff_left  = 0;
	bit            holdoff_done  = 1'b0;
	int            rx_phase      = 0;
	rx_mode_t      rx_mode       = RX_FREE;

	vehicle_fault_supervisor_top u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.battery_codes    (battery_codes),
		.converter_codes  (converter_codes),
		.inverter_codes   (inverter_codes),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.fault_level      (fault_level),
		.kill_flag        (kill_flag),
		.battery_status   (battery_status),
		.converter_status (converter_status),
		.inverter_status  (inverter_status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic health_t rate_six(input logic [11:0] w, input logic [5:0] lone);
		health_t code;
		logic    lone_reg;
		logic    trio_reg;
		logic    seen_prob;
		lone_reg  = 1'b0;
		trio_reg  = 1'b1;
		seen_prob = 1'b0;
		for (int k = 0; k < 6; k++) begin
			code = health_t'(w[2*k +: 2]);
			if (lone[k]) begin
				if (code == H_REGULAR) lone_reg = 1'b1;
			end else if (code != H_REGULAR) begin
				trio_reg = 1'b0;
			end
			if (code == H_PROBLEM) seen_prob = 1'b1;
		end
		if (w == '0) return H_OK;
		if (lone_reg || trio_reg) return H_REGULAR;
		if (seen_prob) return H_PROBLEM;
		return H_DATA_PROBLEM;
	endfunction

	function automatic health_t rate_pair(input logic [3:0] w);
		health_t t;
		health_t v;
		t = health_t'(w[1:0]);
		v = health_t'(w[3:2]);
		if (w == '0) return H_OK;
		if (t == H_REGULAR || v == H_REGULAR) return H_REGULAR;
		if (t == H_PROBLEM || v == H_PROBLEM) return H_PROBLEM;
		return H_DATA_PROBLEM;
	endfunction

	function automatic health_t rand_health();
		int r;
		r = $urandom_range(0, 99);
		if (r < 35) return H_OK;
		if (r < 60) return H_REGULAR;
		if (r < 85) return H_PROBLEM;
		return H_DATA_PROBLEM;
	endfunction

	function automatic logic [11:0] pick_six(input health_t want, input logic [5:0] lone);
		logic [11:0] w;
		if (want == H_OK) return '0;
		do begin
			w = 12'($urandom_range(0, 4095));
		end while (rate_six(w, lone) != want);
		return w;
	endfunction

	task automatic add_tick(input logic [11:0] b, input logic [3:0] c, input logic [11:0] v);
		tick_codes_t t;
		t.battery   = b;
		t.converter = c;
		t.inverter  = v;
		tick_q.push_back(t);
	endtask

	task automatic gen_tick(input bit noise, input bit want_kill, input bit allow_kill);
		health_t     hb;
		health_t     hc;
		health_t     hv;
		logic [11:0] b;
		logic [3:0]  c;
		logic [11:0] v;
		do begin
			if (noise) begin
				b = 12'($urandom_range(0, 4095));
				c = 4'($urandom_range(0, 15));
				v = 12'($urandom_range(0, 4095));
			end else begin
				hb = want_kill ? H_PROBLEM : rand_health();
				hc = want_kill ? H_PROBLEM : rand_health();
				hv = want_kill ? H_PROBLEM : rand_health();
				b  = pick_six(hb, BatteryLoneMask);
				do begin
					c = 4'($urandom_range(0, 15));
				end while (rate_pair(c) != hc);
				v  = pick_six(hv, InverterLoneMask);
			end
		end while (!allow_kill && rate_six(b, BatteryLoneMask) == H_PROBLEM &&
			rate_pair(c) == H_PROBLEM && rate_six(v, InverterLoneMask) == H_PROBLEM);
		add_tick(b, c, v);
	endtask

	function automatic tick_verdict_t judge_tick(input tick_codes_t t, input level_t prev);
		tick_verdict_t r;
		level_t        nxt;
		logic          any_prob;
		logic          any_reg;
		logic          all_ok;
		logic          all_mild;
		r.battery   = rate_six(t.battery, BatteryLoneMask);
		r.converter = rate_pair(t.converter);
		r.inverter  = rate_six(t.inverter, InverterLoneMask);
		r.level     = prev;
		r.kill      = (prev == LVL_AUTOKILL);
		any_prob = (r.battery == H_PROBLEM || r.converter == H_PROBLEM ||
			r.inverter == H_PROBLEM);
		any_reg  = (r.battery == H_REGULAR || r.converter == H_REGULAR ||
			r.inverter == H_REGULAR);
		all_ok   = (r.battery == H_OK && r.converter == H_OK && r.inverter == H_OK);
		all_mild = (r.battery inside {H_OK, H_REGULAR}) &&
			(r.converter inside {H_OK, H_REGULAR}) && (r.inverter inside {H_OK, H_REGULAR});
		nxt = prev;
		if (prev != LVL_AUTOKILL && r.battery == H_PROBLEM && r.converter == H_PROBLEM &&
			r.inverter == H_PROBLEM) begin
			nxt = LVL_AUTOKILL;
		end else begin
			case (prev)
				LVL_OK: begin
					if (any_prob) nxt = LVL_CAUTION2;
					else if (any_reg) nxt = LVL_CAUTION1;
				end
				LVL_CAUTION1: begin
					if (any_prob) nxt = LVL_CAUTION2;
					else if (all_ok) nxt = LVL_OK;
				end
				LVL_CAUTION2: begin
					if (all_mild) nxt = LVL_CAUTION1;
				end
				default: nxt = prev;
			endcase
		end
		level_model = nxt;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			error_cnt++;
		end
	endtask

	// request driver: bursts with random gaps
	always @(negedge clk) begin
		if (arst_n && (!in_valid || req_taken)) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (tick_q.size() > 0) begin
				tick_cur = tick_q.pop_front();
				battery_codes   <= tick_cur.battery;
				converter_codes <= tick_cur.converter;
				inverter_codes  <= tick_cur.inverter;
				in_valid        <= 1'b1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 12);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result receiver stall pattern, with one long hold-off
	always @(negedge clk) begin
		if (!holdoff_done && accepted_cnt >= HoldoffAfter) begin
			holdoff_done = 1'b1;
			holdoff_left = HoldoffCycles;
		end
		if (holdoff_left > 0) begin
			holdoff_left--;
			out_stall <= 1'b1;
		end else begin
			if (rx_phase % 48 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
				RX_FREE:  out_stall <= 1'b0;
				RX_LIGHT: out_stall <= ($urandom_range(0, 4) == 0);
				RX_HEAVY: out_stall <= 1'($urandom_range(0, 1));
				default:  out_stall <= ((rx_phase % 5) < 2);
			endcase
		end
		rx_phase++;
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			level_model = LVL_CAUTION1;
			req_taken   = 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					$error("result with no request pending");
					error_cnt++;
				end else begin
					verdict_cur = verdict_q.pop_front();
					check_field("fault_level", verdict_cur.level, fault_level);
					check_field("kill_flag", {1'b0, verdict_cur.kill}, {1'b0, kill_flag});
					check_field("battery_status", verdict_cur.battery, battery_status);
					check_field("converter_status", verdict_cur.converter, converter_status);
					check_field("inverter_status", verdict_cur.inverter, inverter_status);
				end
			end
			req_taken = in_valid && !in_stall;
			if (req_taken) begin
				tick_cur.battery   = battery_codes;
				tick_cur.converter = converter_codes;
				tick_cur.inverter  = inverter_codes;
				verdict_q.push_back(judge_tick(tick_cur, level_model));
				accepted_cnt++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CycleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		add_tick(12'h000, 4'h0, 12'h000);
		add_tick(12'hFFF, 4'hF, 12'hFFF);
		add_tick(12'h001, 4'h0, 12'h000);
		add_tick(12'h004, 4'h0, 12'h000);
		add_tick(12'h040, 4'h0, 12'h000);
		add_tick(12'h045, 4'h0, 12'h000);
		add_tick(12'h000, 4'h0, 12'h004);
		add_tick(12'h000, 4'h0, 12'h414);
		add_tick(12'h000, 4'h0, 12'h000);
		add_tick(12'h000, 4'h1, 12'h000);
		add_tick(12'h000, 4'h0, 12'h000);
		add_tick(12'h800, 4'h0, 12'h000);
		add_tick(12'h200, 4'h0, 12'h000);
		add_tick(12'hAAA, 4'hA, 12'h000);
		add_tick(12'hFFF, 4'hF, 12'hFFF);
		add_tick(12'h555, 4'h5, 12'h555);
		add_tick(12'h000, 4'h0, 12'h000);
		add_tick(12'h000, 4'h8, 12'h000);
		add_tick(12'h000, 4'h0, 12'h100);
		add_tick(12'h000, 4'h0, 12'h000);
		add_tick(12'h555, 4'h5, 12'h555);
		add_tick(12'h000, 4'h0, 12'hC00);
		add_tick(12'h000, 4'h0, 12'h001);
		add_tick(12'h000, 4'h0, 12'h000);
		for (int i = 0; i < RandomTicks; i++) begin
			gen_tick(i % 8 == 5, i == KillTick, i >= KillTick);
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (tick_q.size() != 0 || in_valid || verdict_q.size() != 0) begin
			@(posedge clk);
			#1;
		end
		repeat (8) @(posedge clk);
		if (error_cnt == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/vfs_pkg.sv
rtl/vfs_status.sv
rtl/vfs_fsm.sv
rtl/vehicle_fault_supervisor_top.sv
tb/sv/tb.sv
